[sv/vam_pkg.sv]
// ----------------------------------------------------------------------------
// vam_pkg: shared types and constants for the vector angle and magnitude unit
// Request and result payloads, the per-cell state word, fixed widths and the
// CORDIC arctangent table in units of 2^-20 degree.
// ----------------------------------------------------------------------------
package vam_pkg;

	localparam int COORD_W     = 16;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int GUARD       = 24;
	localparam int XY_W        = COORD_W + GUARD + 4;
	localparam int Z_W         = 28;
	localparam int A_W         = 30;
	localparam int TAB_LEN     = 24;
	localparam int ANG_W       = 16;
	localparam int MAG_W       = 17;
	localparam int SQ_W        = 2 * MAG_W + 1;
	localparam int SQRT_DIGITS = (SQ_W + 1) / 2;
	localparam int RT_W        = 2 * SQRT_DIGITS;
	localparam int ANG_SHIFT   = 13;
	localparam int ANG_WRAP    = 46080;

	localparam logic [MAG_W-1:0]      MAG_MAX    = MAG_W'(92681);
	localparam logic signed [A_W-1:0] DEG180     = A_W'(180 * (1 << 20));
	localparam logic signed [A_W-1:0] DEG360     = A_W'(360 * (1 << 20));
	localparam logic [A_W-1:0]        ROUND_HALF = A_W'(1 << (ANG_SHIFT - 1));

	typedef struct packed {
		logic signed [COORD_W-1:0] src_x;
		logic signed [COORD_W-1:0] src_y;
		logic signed [COORD_W-1:0] dst_x;
		logic signed [COORD_W-1:0] dst_y;
	} vam_req_t;

	typedef struct packed {
		logic [ANG_W-1:0] angle_deg;
		logic [MAG_W-1:0] magnitude;
	} vam_res_t;

	typedef struct packed {
		logic half_turn;
		logic zero;
		logic sat;
	} vam_flags_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic [RT_W-1:0]        rem;
		logic [RT_W-1:0]        root;
		vam_flags_t             flags;
	} vam_cell_t;

	// atan(2^-i) in degrees, scaled by 2^20 and rounded
	function automatic logic signed [Z_W-1:0] atan_step(input int idx);
		case (idx)
			0:       return Z_W'(47185920);
			1:       return Z_W'(27855475);
			2:       return Z_W'(14718068);
			3:       return Z_W'(7471121);
			4:       return Z_W'(3750058);
			5:       return Z_W'(1876857);
			6:       return Z_W'(938658);
			7:       return Z_W'(469357);
			8:       return Z_W'(234682);
			9:       return Z_W'(117342);
			10:      return Z_W'(58671);
			11:      return Z_W'(29335);
			12:      return Z_W'(14668);
			13:      return Z_W'(7334);
			14:      return Z_W'(3667);
			15:      return Z_W'(1833);
			16:      return Z_W'(917);
			17:      return Z_W'(458);
			18:      return Z_W'(229);
			19:      return Z_W'(115);
			20:      return Z_W'(57);
			21:      return Z_W'(29);
			22:      return Z_W'(14);
			23:      return Z_W'(7);
			default: return '0;
		endcase
	endfunction

endpackage

[sv/vector_angle_magnitude_unit.sv]
// ----------------------------------------------------------------------------
// vector_angle_magnitude_unit: angle and length of a point displacement
// Front end, chain of CORDIC and square-root cells, back end, output skid.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_stall is low: a source and a
// destination point in signed Q12.4. Each result gives the angle of
// atan2(-dy, dx) in [0, 360) degrees in 1/128 degree steps and the rounded
// length of (dx, dy) in Q.4, clamped to 92681. A zero vector returns zero
// for both. The path has three front-end stages, CHAIN_LEN cells (the larger
// of CORDIC_STAGES capped at 24 and 18 square-root digits), one per stage,
// two back-end stages and the output register. Each is a register, so one
// request enters and one result leaves each cycle unless stalled. A two-entry
// output register and skid buffer keep request-side stall registered.
module vector_angle_magnitude_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  vam_pkg::vam_req_t req,
	output logic              res_valid,
	input  logic              res_stall,
	output vam_pkg::vam_res_t res
);
	import vam_pkg::*;

	localparam int ROT_N     = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
	localparam int CHAIN_LEN = (ROT_N > SQRT_DIGITS) ? ROT_N : SQRT_DIGITS;

	logic      en;
	logic      chain_v [CHAIN_LEN+1];
	vam_cell_t chain_d [CHAIN_LEN+1];
	logic      post_v;
	vam_res_t  post_res;

	logic      res_valid_q, skid_full_q;
	vam_res_t  res_q, skid_q;

	// freeze the pipeline while the skid holds a result
	assign en        = !skid_full_q;
	assign req_stall = skid_full_q;

	vam_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (req_valid),
		.req       (req),
		.valid_out (chain_v[0]),
		.cell_out  (chain_d[0])
	);

	for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
		vam_cell #(
			.IDX        (i),
			.ROT_STAGES (ROT_N)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (chain_v[i]),
			.cell_in   (chain_d[i]),
			.valid_out (chain_v[i+1]),
			.cell_out  (chain_d[i+1])
		);
	end

	vam_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (chain_v[CHAIN_LEN]),
		.cell_in   (chain_d[CHAIN_LEN]),
		.valid_out (post_v),
		.res       (post_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (res_valid_q && res_stall) begin
			if (en && post_v) begin
				skid_full_q <= 1'b1;
			end
		end else if (skid_full_q) begin
			res_valid_q <= 1'b1;
			skid_full_q <= 1'b0;
		end else begin
			res_valid_q <= post_v;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid_q && res_stall) begin
			if (en && post_v) begin
				skid_q <= post_res;
			end
		end else if (skid_full_q) begin
			res_q <= skid_q;
		end else begin
			res_q <= post_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_skid_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> res_valid_q)
		else $error("skid holds a result while the output is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(res_valid_q && res_stall))
		else $error("skid filled without a stalled output");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && !res_stall |=> !skid_full_q && res_valid_q)
		else $error("skid did not drain into the output register");

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.angle_deg < ANG_W'(ANG_WRAP)) && (res_q.magnitude <= MAG_MAX))
		else $error("result outside its range");
`endif

endmodule

[sv/vam_prep.sv]
// ----------------------------------------------------------------------------
// vam_prep: front end of the angle and magnitude pipeline
// Forms the displacement, folds the left half-plane onto the right, squares
// both components and loads the state word for the first cell.
// ----------------------------------------------------------------------------
module vam_prep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  vam_pkg::vam_req_t  req,
	output logic               valid_out,
	output vam_pkg::vam_cell_t cell_out
);
	import vam_pkg::*;

	localparam int PAD   = XY_W - DIFF_W - 1 - GUARD;
	localparam int CMP_W = DIFF_W + MAG_W;

	logic                     v_s1, v_s2, v_s3;
	logic signed [DIFF_W-1:0] dx_c, dy_c;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;

	logic signed [DIFF_W:0]   dxe, dye, vx, vy;
	logic [DIFF_W-1:0]        ax, ay;
	logic [MAG_W-1:0]         mx, my;
	logic                     neg, sat_c;

	logic signed [XY_W-1:0]   x_s2, y_s2;
	vam_flags_t               flags_s2;
	logic [2*MAG_W-1:0]       sq_x_s2, sq_y_s2;
	vam_cell_t                cell_s3;

	assign dx_c = {req.dst_x[COORD_W-1], req.dst_x} - {req.src_x[COORD_W-1], req.src_x};
	assign dy_c = {req.dst_y[COORD_W-1], req.dst_y} - {req.src_y[COORD_W-1], req.src_y};

	always_comb begin
		neg   = dx_s1[DIFF_W-1];
		dxe   = {dx_s1[DIFF_W-1], dx_s1};
		dye   = {dy_s1[DIFF_W-1], dy_s1};
		// turn by a half circle when the vector points left
		vx    = neg ? -dxe : dxe;
		vy    = neg ? dye : -dye;
		ax    = neg ? DIFF_W'(-dx_s1) : dx_s1;
		ay    = dy_s1[DIFF_W-1] ? DIFF_W'(-dy_s1) : dy_s1;
		sat_c = (CMP_W'(ax) >= CMP_W'(MAG_MAX)) || (CMP_W'(ay) >= CMP_W'(MAG_MAX));
		mx    = sat_c ? '0 : MAG_W'(ax);
		my    = sat_c ? '0 : MAG_W'(ay);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;

			x_s2               <= {{PAD{vx[DIFF_W]}}, vx, {GUARD{1'b0}}};
			y_s2               <= {{PAD{vy[DIFF_W]}}, vy, {GUARD{1'b0}}};
			flags_s2.half_turn <= neg;
			flags_s2.zero      <= (dx_s1 == '0) && (dy_s1 == '0);
			flags_s2.sat       <= sat_c;
			sq_x_s2            <= mx * mx;
			sq_y_s2            <= my * my;

			cell_s3.x     <= x_s2;
			cell_s3.y     <= y_s2;
			cell_s3.z     <= '0;
			cell_s3.rem   <= RT_W'(SQ_W'(sq_x_s2) + SQ_W'(sq_y_s2));
			cell_s3.root  <= '0;
			cell_s3.flags <= flags_s2;
		end
	end

	assign valid_out = v_s3;
	assign cell_out  = cell_s3;

endmodule

[sv/vam_cell.sv]
// ----------------------------------------------------------------------------
// vam_cell: one link of the angle and magnitude chain
// Applies one CORDIC micro-rotation (IDX < ROT_STAGES) and one digit of the
// integer square root (IDX < SQRT_DIGITS); the next cell gets the state word.
// ----------------------------------------------------------------------------
module vam_cell #(
	parameter int IDX        = 0,
	parameter int ROT_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  vam_pkg::vam_cell_t cell_in,
	output logic               valid_out,
	output vam_pkg::vam_cell_t cell_out
);
	import vam_pkg::*;

	localparam bit DO_ROT  = IDX < ROT_STAGES;
	localparam bit DO_SQRT = IDX < SQRT_DIGITS;
	localparam int BIT_POS = DO_SQRT ? 2 * (SQRT_DIGITS - 1 - IDX) : 0;
	localparam logic [RT_W-1:0]       BIT = RT_W'(1) << BIT_POS;
	localparam logic signed [Z_W-1:0] ANG = atan_step(IDX);

	logic signed [XY_W-1:0] xs, ys;
	logic [RT_W:0]          trial;
	vam_cell_t              nxt;
	vam_cell_t              cell_s1;
	logic                   valid_s1;

	always_comb begin
		nxt   = cell_in;
		xs    = cell_in.x >>> IDX;
		ys    = cell_in.y >>> IDX;
		trial = {1'b0, cell_in.root} + {1'b0, BIT};
		if (DO_ROT) begin
			// drive y towards zero, accumulate the angle turned
			if (cell_in.y > 0) begin
				nxt.x = cell_in.x + ys;
				nxt.y = cell_in.y - xs;
				nxt.z = cell_in.z + ANG;
			end else begin
				nxt.x = cell_in.x - ys;
				nxt.y = cell_in.y + xs;
				nxt.z = cell_in.z - ANG;
			end
		end
		if (DO_SQRT) begin
			if ({1'b0, cell_in.rem} >= trial) begin
				nxt.rem  = cell_in.rem - trial[RT_W-1:0];
				nxt.root = (cell_in.root >> 1) + BIT;
			end else begin
				nxt.root = cell_in.root >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_s1 <= nxt;
		end
	end

	assign valid_out = valid_s1;
	assign cell_out  = cell_s1;

endmodule

[sv/vam_post.sv]
// ----------------------------------------------------------------------------
// vam_post: back end of the angle and magnitude pipeline
// Adds the half-turn offset, wraps and rounds the angle, rounds and clamps the
// length, and forces a zero vector to a zero result.
// ----------------------------------------------------------------------------
module vam_post (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  vam_pkg::vam_cell_t cell_in,
	output logic               valid_out,
	output vam_pkg::vam_res_t  res
);
	import vam_pkg::*;

	localparam int AF_W = A_W - ANG_SHIFT;

	logic                  v_s1, v_s2;
	logic signed [A_W-1:0] a_s1, a_s2;
	logic [RT_W-1:0]       mag_s1;
	logic [MAG_W-1:0]      mag_s2;
	vam_flags_t            flags_s1;
	logic                  zero_s2;

	logic signed [A_W-1:0] base;
	logic [A_W-1:0]        a_sum;
	logic [AF_W-1:0]       ang_full;

	assign base = cell_in.flags.half_turn ? DEG180 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= base + A_W'(cell_in.z);
			// round half up: the remainder exceeds the root
			mag_s1   <= cell_in.root + RT_W'(cell_in.rem > cell_in.root);
			flags_s1 <= cell_in.flags;

			if (a_s1 < 0) begin
				a_s2 <= a_s1 + DEG360;
			end else if (a_s1 >= DEG360) begin
				a_s2 <= a_s1 - DEG360;
			end else begin
				a_s2 <= a_s1;
			end
			if (flags_s1.sat || (mag_s1 > RT_W'(MAG_MAX))) begin
				mag_s2 <= MAG_MAX;
			end else begin
				mag_s2 <= MAG_W'(mag_s1);
			end
			zero_s2 <= flags_s1.zero;
		end
	end

	always_comb begin
		a_sum    = A_W'(a_s2) + ROUND_HALF;
		ang_full = a_sum[A_W-1:ANG_SHIFT];
		if (zero_s2) begin
			res.angle_deg = '0;
			res.magnitude = '0;
		end else begin
			// a full turn after rounding folds back to zero
			res.angle_deg = (ang_full >= AF_W'(ANG_WRAP)) ? '0 : ANG_W'(ang_full);
			res.magnitude = mag_s2;
		end
	end

	assign valid_out = v_s2;

endmodule
